[rtl/core/wmf_pkg.sv]
// Shared constants, types and compare helpers for the 3x3 median/mean filter.
package wmf_pkg;

  localparam int MAX_LINE_WIDTH = 1024;
  localparam int WINDOW_SIZE    = 3;
  localparam int WIN_CELLS      = WINDOW_SIZE * WINDOW_SIZE;
  localparam int MIN_LINE_WIDTH = 3;

  localparam int PIX_W = 8;
  localparam int ROW_W = 16;
  localparam int COL_W = $clog2(MAX_LINE_WIDTH);
  localparam int LW_W  = 11;

  localparam int ROW_SUM_W = PIX_W + 2;
  localparam int SUM_W     = PIX_W + 4;

  // floor(s / 9) == (s * ceil(2^16 / 9)) >> 16 for every s below 2^15
  localparam int               MEAN_SHIFT   = 16;
  localparam int               MEAN_RECIP_W = 13;
  localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP = MEAN_RECIP_W'(7282);
  localparam int               PROD_W       = SUM_W + MEAN_RECIP_W;

  localparam logic [ROW_W-1:0] ROW_MAX = '1;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [0:0] {
    CFG_FILTER_MODE = 1'b0,
    CFG_LINE_WIDTH  = 1'b1
  } cfg_index_t;

  typedef enum logic {
    MODE_MEDIAN = 1'b0,
    MODE_MEAN   = 1'b1
  } filter_mode_t;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic             has_result;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tag_t;

  typedef struct packed {
    pixel_t           value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } result_t;

  typedef struct packed {
    pixel_t lo;
    pixel_t md;
    pixel_t hi;
  } triple_t;

  function automatic triple_t sort3(pixel_t a, pixel_t b, pixel_t c);
    pixel_t  x;
    pixel_t  y;
    pixel_t  z;
    pixel_t  t;
    triple_t r;
    x = a;
    y = b;
    z = c;
    if (x > y) begin
      t = x; x = y; y = t;
    end
    if (y > z) begin
      t = y; y = z; z = t;
    end
    if (x > y) begin
      t = x; x = y; y = t;
    end
    r.lo = x;
    r.md = y;
    r.hi = z;
    return r;
  endfunction

  function automatic pixel_t median3(pixel_t a, pixel_t b, pixel_t c);
    triple_t s;
    s = sort3(a, b, c);
    return s.md;
  endfunction

  function automatic pixel_t max3(pixel_t a, pixel_t b, pixel_t c);
    pixel_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic pixel_t min3(pixel_t a, pixel_t b, pixel_t c);
    pixel_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

[rtl/core/wmf_line_store.sv]
// Two line memories holding the previous two rows, with a registered read.
module wmf_line_store (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [wmf_pkg::COL_W-1:0]  rd_addr,
  output wmf_pkg::pixel_t            rd_upper,
  output wmf_pkg::pixel_t            rd_middle,
  input  logic                       wr_en,
  input  logic [wmf_pkg::COL_W-1:0]  wr_addr,
  input  wmf_pkg::pixel_t            wr_upper,
  input  wmf_pkg::pixel_t            wr_middle
);

  wmf_pkg::pixel_t upper_mem  [wmf_pkg::MAX_LINE_WIDTH];
  wmf_pkg::pixel_t middle_mem [wmf_pkg::MAX_LINE_WIDTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper  <= upper_mem[rd_addr];
      rd_middle <= middle_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
  end

endmodule

[rtl/core/wmf_window_calc.sv]
// 3x3 window register and the pipelined median / mean datapath.
module wmf_window_calc (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  shift_en,
  input  wmf_pkg::tag_t         tag_in,
  input  wmf_pkg::pixel_t       new_top,
  input  wmf_pkg::pixel_t       new_mid,
  input  wmf_pkg::pixel_t       new_pix,
  input  wmf_pkg::filter_mode_t mode,
  output logic                  done_valid,
  output wmf_pkg::tag_t         done_tag,
  output wmf_pkg::pixel_t       done_value
);

  localparam int WS = wmf_pkg::WINDOW_SIZE;

  wmf_pkg::pixel_t  win [wmf_pkg::WIN_CELLS];

  logic             p2_valid;
  wmf_pkg::tag_t    p2_tag;

  logic             p3_valid;
  wmf_pkg::tag_t    p3_tag;
  wmf_pkg::triple_t p3_tri  [WS];
  logic [wmf_pkg::ROW_SUM_W-1:0] p3_rsum [WS];

  logic             p4_valid;
  wmf_pkg::tag_t    p4_tag;
  wmf_pkg::pixel_t  p4_lo;
  wmf_pkg::pixel_t  p4_md;
  wmf_pkg::pixel_t  p4_hi;
  logic [wmf_pkg::SUM_W-1:0] p4_sum;

  logic [wmf_pkg::PROD_W-1:0] mean_prod;
  wmf_pkg::pixel_t  median_val;
  wmf_pkg::pixel_t  mean_val;

  // window: shift left one column, new column enters on the right
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < wmf_pkg::WIN_CELLS; k++) begin
        win[k] <= '0;
      end
    end else if (shift_en) begin
      for (int r = 0; r < WS; r++) begin
        for (int c = 0; c < WS - 1; c++) begin
          win[r*WS + c] <= win[r*WS + c + 1];
        end
      end
      win[WS-1]         <= new_top;
      win[2*WS-1]       <= new_mid;
      win[WS*WS-1]      <= new_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
    end else begin
      p2_valid <= shift_en;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
    end
  end

  // sort each row, then max of mins / median of medians / min of maxes
  always_ff @(posedge clk) begin
    p2_tag <= tag_in;
    p3_tag <= p2_tag;
    for (int r = 0; r < WS; r++) begin
      p3_tri[r]  <= wmf_pkg::sort3(win[r*WS], win[r*WS + 1], win[r*WS + 2]);
      p3_rsum[r] <= wmf_pkg::ROW_SUM_W'(win[r*WS])
                  + wmf_pkg::ROW_SUM_W'(win[r*WS + 1])
                  + wmf_pkg::ROW_SUM_W'(win[r*WS + 2]);
    end
    p4_tag <= p3_tag;
    p4_lo  <= wmf_pkg::max3(p3_tri[0].lo, p3_tri[1].lo, p3_tri[2].lo);
    p4_md  <= wmf_pkg::median3(p3_tri[0].md, p3_tri[1].md, p3_tri[2].md);
    p4_hi  <= wmf_pkg::min3(p3_tri[0].hi, p3_tri[1].hi, p3_tri[2].hi);
    p4_sum <= wmf_pkg::SUM_W'(p3_rsum[0]) + wmf_pkg::SUM_W'(p3_rsum[1])
            + wmf_pkg::SUM_W'(p3_rsum[2]);
  end

  always_comb begin
    median_val = wmf_pkg::median3(p4_lo, p4_md, p4_hi);
    mean_prod  = wmf_pkg::PROD_W'(p4_sum) * wmf_pkg::PROD_W'(wmf_pkg::MEAN_RECIP);
    mean_val   = mean_prod[wmf_pkg::MEAN_SHIFT +: wmf_pkg::PIX_W];
    done_value = (mode == wmf_pkg::MODE_MEAN) ? mean_val : median_val;
  end

  assign done_valid = p4_valid;
  assign done_tag   = p4_tag;

endmodule

[rtl/core/wmf_out_fifo.sv]
// Result queue that decouples the filter pipeline from the output stall.
module wmf_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wmf_pkg::result_t push_data,
  input  logic             pop,
  output logic             not_empty,
  output wmf_pkg::result_t head
);

  wmf_pkg::result_t             mem [wmf_pkg::FIFO_DEPTH];
  logic [wmf_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [wmf_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [wmf_pkg::OCC_W-1:0]    count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + wmf_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + wmf_pkg::FIFO_AW'(1);
      end
      count <= count + wmf_pkg::OCC_W'(push) - wmf_pkg::OCC_W'(pop);
    end
  end

  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

endmodule

[rtl/core/window3x3_median_mean_filter.sv]
// Top level of the streaming 3x3 median / mean filter.
// Takes one padded 8-bit pixel per clock in raster order and, once a full 3x3
// window exists (row and column at least 2), gives the median (filter_mode 0)
// or truncated mean (filter_mode 1) of the window with the centre's row and
// column. Sustained rate is one pixel per clock; a result passes the input,
// window, row-sort and combine registers and the result queue. The line memories
// are read in the transfer cycle and written back in the next cycle; when a
// pixel revisits the column of the pixel before it (frame_start right after a
// column-0 pixel), the write-back data is forwarded in place of the memory
// read. An 8-entry result queue absorbs output stalls, and in_stall rises once
// 8 pixels are in flight or queued. The line memories are not cleared: start
// each image with frame_start and keep line_width fixed within a frame.
module window3x3_median_mean_filter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  wmf_pkg::cfg_index_t         cfg_index,
  input  logic [wmf_pkg::LW_W-1:0]    cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [wmf_pkg::PIX_W-1:0]   pixel_value,
  input  logic                        frame_start,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [wmf_pkg::PIX_W-1:0]   filtered_value,
  output logic [wmf_pkg::ROW_W-1:0]   centre_row,
  output logic [wmf_pkg::COL_W-1:0]   centre_col
);

  wmf_pkg::filter_mode_t         filter_mode;
  logic [wmf_pkg::LW_W-1:0]      line_width;

  logic [wmf_pkg::COL_W-1:0]     column_count;
  logic [wmf_pkg::COL_W-1:0]     column_count_next;
  logic [wmf_pkg::ROW_W-1:0]     row_count;
  logic [wmf_pkg::ROW_W-1:0]     row_count_next;

  logic [wmf_pkg::LW_W-1:0]      eff_width;
  logic [wmf_pkg::COL_W-1:0]     start_col;
  logic [wmf_pkg::ROW_W-1:0]     start_row;
  logic [wmf_pkg::COL_W-1:0]     cur_col;
  logic [wmf_pkg::ROW_W-1:0]     cur_row;
  wmf_pkg::tag_t                 cur_tag;

  logic                          accept;
  logic                          pop;
  logic                          push;
  logic                          drop;
  logic [wmf_pkg::OCC_W-1:0]     occ;

  logic                          p1_valid;
  wmf_pkg::pixel_t               p1_pix;
  logic [wmf_pkg::COL_W-1:0]     p1_col;
  wmf_pkg::tag_t                 p1_tag;

  wmf_pkg::pixel_t               rd_upper;
  wmf_pkg::pixel_t               rd_middle;

  logic                          fwd_hit;
  wmf_pkg::pixel_t               fwd_upper;
  wmf_pkg::pixel_t               fwd_middle;
  wmf_pkg::pixel_t               col_upper;
  wmf_pkg::pixel_t               col_middle;

  logic                          done_valid;
  wmf_pkg::tag_t                 done_tag;
  wmf_pkg::pixel_t               done_value;
  wmf_pkg::result_t              push_data;
  wmf_pkg::result_t              head;

  function automatic logic [wmf_pkg::ROW_W-1:0] row_inc(logic [wmf_pkg::ROW_W-1:0] r);
    return (r == wmf_pkg::ROW_MAX) ? r : r + wmf_pkg::ROW_W'(1);
  endfunction

  assign in_stall = (occ == wmf_pkg::OCC_W'(wmf_pkg::FIFO_DEPTH));
  assign accept   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;
  assign push     = done_valid && done_tag.has_result;
  assign drop     = done_valid && !done_tag.has_result;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= wmf_pkg::MODE_MEDIAN;
      line_width  <= wmf_pkg::LW_W'(640);
    end else if (cfg_write) begin
      unique case (cfg_index)
        wmf_pkg::CFG_FILTER_MODE: filter_mode <= wmf_pkg::filter_mode_t'(cfg_data[0]);
        wmf_pkg::CFG_LINE_WIDTH:  line_width  <= cfg_data;
      endcase
    end
  end

  // position of the incoming pixel and of the next one
  always_comb begin
    if (line_width < wmf_pkg::LW_W'(wmf_pkg::MIN_LINE_WIDTH)) begin
      eff_width = wmf_pkg::LW_W'(wmf_pkg::MIN_LINE_WIDTH);
    end else if (line_width > wmf_pkg::LW_W'(wmf_pkg::MAX_LINE_WIDTH)) begin
      eff_width = wmf_pkg::LW_W'(wmf_pkg::MAX_LINE_WIDTH);
    end else begin
      eff_width = line_width;
    end

    start_col = frame_start ? '0 : column_count;
    start_row = frame_start ? '0 : row_count;

    // column past a lowered width wraps to the next row
    if (wmf_pkg::LW_W'(start_col) >= eff_width) begin
      cur_col = '0;
      cur_row = row_inc(start_row);
    end else begin
      cur_col = start_col;
      cur_row = start_row;
    end

    if (wmf_pkg::LW_W'(cur_col) + wmf_pkg::LW_W'(1) >= eff_width) begin
      column_count_next = '0;
      row_count_next    = row_inc(cur_row);
    end else begin
      column_count_next = cur_col + wmf_pkg::COL_W'(1);
      row_count_next    = cur_row;
    end

    cur_tag.has_result = (cur_row >= wmf_pkg::ROW_W'(2)) && (cur_col >= wmf_pkg::COL_W'(2));
    cur_tag.row        = cur_row - wmf_pkg::ROW_W'(1);
    cur_tag.col        = cur_col - wmf_pkg::COL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      p1_valid     <= 1'b0;
      occ          <= '0;
    end else begin
      if (accept) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end
      p1_valid <= accept;
      occ      <= occ + wmf_pkg::OCC_W'(accept) - wmf_pkg::OCC_W'(pop)
                - wmf_pkg::OCC_W'(drop);
    end
  end

  // read of the column being written back this cycle takes the write data
  always_ff @(posedge clk) begin
    p1_pix     <= pixel_value;
    p1_col     <= cur_col;
    p1_tag     <= cur_tag;
    fwd_hit    <= p1_valid && (p1_col == cur_col);
    fwd_upper  <= col_middle;
    fwd_middle <= p1_pix;
  end

  assign col_upper  = fwd_hit ? fwd_upper : rd_upper;
  assign col_middle = fwd_hit ? fwd_middle : rd_middle;

  wmf_line_store u_line_store (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (cur_col),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle),
    .wr_en     (p1_valid),
    .wr_addr   (p1_col),
    .wr_upper  (col_middle),
    .wr_middle (p1_pix)
  );

  wmf_window_calc u_calc (
    .clk        (clk),
    .rst        (rst),
    .shift_en   (p1_valid),
    .tag_in     (p1_tag),
    .new_top    (col_upper),
    .new_mid    (col_middle),
    .new_pix    (p1_pix),
    .mode       (filter_mode),
    .done_valid (done_valid),
    .done_tag   (done_tag),
    .done_value (done_value)
  );

  always_comb begin
    push_data.value = done_value;
    push_data.row   = done_tag.row;
    push_data.col   = done_tag.col;
  end

  wmf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .not_empty (out_valid),
    .head      (head)
  );

  assign filtered_value = head.value;
  assign centre_row     = head.row;
  assign centre_col     = head.col;

endmodule

[rtl/core/wmf_checker.sv]
// Port-level checks for the 3x3 filter top level, with its bind.
module wmf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [wmf_pkg::PIX_W-1:0]   filtered_value,
  input logic [wmf_pkg::ROW_W-1:0]   centre_row,
  input logic [wmf_pkg::COL_W-1:0]   centre_col
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(filtered_value)
      && $stable(centre_row) && $stable(centre_col))
    else $error("stalled result changed");

  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled after reset");

  // window centre never sits on the padded border row 0 or column 0
  a_centre_inner: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> centre_row != '0 && centre_col != '0)
    else $error("centre on top or left border");

  a_centre_col_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> centre_col != '1)
    else $error("centre column beyond last inner column");

endmodule

bind window3x3_median_mean_filter wmf_checker u_wmf_checker (
  .clk            (clk),
  .rst            (rst),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .filtered_value (filtered_value),
  .centre_row     (centre_row),
  .centre_col     (centre_col)
);

[test/tb.sv]
// Self-checking testbench for the streaming 3x3 median / mean filter.
`timescale 1ns / 100ps

module tb;

  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 16;
  localparam int STYLE_RANDOM  = 0;
  localparam int STYLE_EXTREME = 1;
  localparam int STYLE_FLAT    = 2;

  typedef struct packed {
    logic [wmf_pkg::PIX_W-1:0] pix;
    logic                      fs;
  } pixel_item_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write = 1'b0;
  wmf_pkg::cfg_index_t         cfg_index = wmf_pkg::CFG_FILTER_MODE;
  logic [wmf_pkg::LW_W-1:0]    cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [wmf_pkg::PIX_W-1:0]   pixel_value = '0;
  logic                        frame_start = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [wmf_pkg::PIX_W-1:0]   filtered_value;
  logic [wmf_pkg::ROW_W-1:0]   centre_row;
  logic [wmf_pkg::COL_W-1:0]   centre_col;

  window3x3_median_mean_filter u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pixel_value    (pixel_value),
    .frame_start    (frame_start),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_value (filtered_value),
    .centre_row     (centre_row),
    .centre_col     (centre_col)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predictor state
  wmf_pkg::filter_mode_t     mode_now;
  logic [wmf_pkg::LW_W-1:0]  width_now;
  logic [wmf_pkg::PIX_W-1:0] line_up  [wmf_pkg::MAX_LINE_WIDTH];
  logic [wmf_pkg::PIX_W-1:0] line_mid [wmf_pkg::MAX_LINE_WIDTH];
  logic [wmf_pkg::PIX_W-1:0] win [wmf_pkg::WIN_CELLS];
  int                        col_pos;
  int                        row_pos;

  pixel_item_t      pixel_feed[$];
  wmf_pkg::result_t filtered_due[$];

  bit item_staged;
  bit pace_sender;
  int burst_left;
  int gap_left;
  int hold_req;
  int hold_seen;
  int hold_left;
  int seg_left;
  int stall_pct;
  int quiet_cycles;
  int mismatches;

  function automatic int eff_width_of(input logic [wmf_pkg::LW_W-1:0] v);
    if (v < wmf_pkg::MIN_LINE_WIDTH) return wmf_pkg::MIN_LINE_WIDTH;
    if (v > wmf_pkg::MAX_LINE_WIDTH) return wmf_pkg::MAX_LINE_WIDTH;
    return int'(v);
  endfunction

  function automatic logic [wmf_pkg::PIX_W-1:0] make_pixel(input int style);
    case (style)
      STYLE_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 8'd0;
          1: return 8'd1;
          2: return 8'd254;
          default: return 8'd255;
        endcase
      end
      STYLE_FLAT: return wmf_pkg::PIX_W'(125 + $urandom_range(0, 6));
      default: return wmf_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // one accepted pixel: update line stores and window, emit the centre result if full
  task automatic advance_window(input logic [wmf_pkg::PIX_W-1:0] pix, input logic fs);
    int                        w;
    int                        c;
    int                        r;
    int                        k;
    int                        j;
    int                        sum;
    logic [wmf_pkg::PIX_W-1:0] top;
    logic [wmf_pkg::PIX_W-1:0] mid;
    logic [wmf_pkg::PIX_W-1:0] key;
    logic [wmf_pkg::PIX_W-1:0] srt [wmf_pkg::WIN_CELLS];
    wmf_pkg::result_t          res;
    w = eff_width_of(width_now);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    // width lowered mid-row: wrap to the next row
    if (col_pos >= w) begin
      col_pos = 0;
      if (row_pos < int'(wmf_pkg::ROW_MAX)) row_pos++;
    end
    c = col_pos;
    r = row_pos;
    top = line_up[c];
    mid = line_mid[c];
    line_up[c] = mid;
    line_mid[c] = pix;
    for (k = 0; k < wmf_pkg::WINDOW_SIZE; k++) begin
      win[k*3]     = win[k*3 + 1];
      win[k*3 + 1] = win[k*3 + 2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = pix;
    if (c + 1 >= w) begin
      col_pos = 0;
      if (row_pos < int'(wmf_pkg::ROW_MAX)) row_pos++;
    end else begin
      col_pos = c + 1;
    end
    if (r >= 2 && c >= 2) begin
      if (mode_now == wmf_pkg::MODE_MEAN) begin
        sum = 0;
        for (k = 0; k < wmf_pkg::WIN_CELLS; k++) sum += int'(win[k]);
        res.value = wmf_pkg::PIX_W'(sum / 9);
      end else begin
        for (k = 0; k < wmf_pkg::WIN_CELLS; k++) srt[k] = win[k];
        for (k = 1; k < wmf_pkg::WIN_CELLS; k++) begin
          key = srt[k];
          j = k - 1;
          while (j >= 0 && srt[j] > key) begin
            srt[j+1] = srt[j];
            j--;
          end
          srt[j+1] = key;
        end
        res.value = srt[wmf_pkg::WIN_CELLS/2];
      end
      res.row = wmf_pkg::ROW_W'(r - 1);
      res.col = wmf_pkg::COL_W'(c - 1);
      filtered_due.push_back(res);
    end
  endtask

  // sender: bursts with random gaps, payload held while stalled
  always @(posedge clk) begin
    pixel_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      item_staged = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_window(pixel_value, frame_start);
        item_staged = 1'b0;
      end
      if (!item_staged) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pixel_feed.size() > 0) begin
          nxt = pixel_feed.pop_front();
          in_valid <= 1'b1;
          pixel_value <= nxt.pix;
          frame_start <= nxt.fs;
          item_staged = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = (pace_sender && $urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : 0;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(5, 60);
          case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 25;
            3: stall_pct = 50;
            default: stall_pct = 90;
          endcase
        end
        seg_left--;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    wmf_pkg::result_t want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && !out_stall) begin
        if (filtered_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: value %0d row %0d col %0d",
                     filtered_value, centre_row, centre_col);
        end else begin
          want = filtered_due.pop_front();
          if (want.value !== filtered_value || want.row !== centre_row ||
              want.col !== centre_col) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp value %0d row %0d col %0d, got value %0d row %0d col %0d",
                       want.value, want.row, want.col,
                       filtered_value, centre_row, centre_col);
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input wmf_pkg::cfg_index_t idx,
                           input logic [wmf_pkg::LW_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == wmf_pkg::CFG_FILTER_MODE) mode_now = wmf_pkg::filter_mode_t'(data[0]);
    else width_now = data;
  endtask

  // everything sent and checked, then room for pixels that make no result
  task automatic wait_drained();
    while (pixel_feed.size() != 0 || item_staged || filtered_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put(input logic [wmf_pkg::PIX_W-1:0] pix, input logic fs);
    pixel_item_t it;
    it.pix = pix;
    it.fs = fs;
    pixel_feed.push_back(it);
  endtask

  task automatic queue_pixels(input int count, input int style, input int restart_odds,
                              input bit fresh);
    int k;
    for (k = 0; k < count; k++)
      put(make_pixel(style),
          (k == 0 && fresh) || (restart_odds != 0 && $urandom_range(1, restart_odds) == 1));
  endtask

  initial begin
    int i;
    int eff;
    int rows;
    int n;
    int items_done;
    mode_now = wmf_pkg::MODE_MEDIAN;
    width_now = wmf_pkg::LW_W'(640);
    col_pos = 0;
    row_pos = 0;
    for (i = 0; i < wmf_pkg::MAX_LINE_WIDTH; i++) begin
      line_up[i] = '0;
      line_mid[i] = '0;
    end
    for (i = 0; i < wmf_pkg::WIN_CELLS; i++) win[i] = '0;
    pace_sender = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 640 wide, so a short frame gives no result
    queue_pixels(20, STYLE_RANDOM, 0, 1'b1);
    wait_drained();

    // median, width 0 taken as 3, upper data bits ignored by the mode register
    write_reg(wmf_pkg::CFG_FILTER_MODE, 11'h7FE);
    write_reg(wmf_pkg::CFG_LINE_WIDTH, 11'd0);
    put(8'd255, 1'b1); put(8'd255, 1'b0); put(8'd255, 1'b0);
    put(8'd0, 1'b0);   put(8'd0, 1'b0);   put(8'd0, 1'b0);
    put(8'd255, 1'b0); put(8'd0, 1'b0);   put(8'd255, 1'b0);
    put(8'd0, 1'b0);   put(8'd255, 1'b0); put(8'd0, 1'b0);
    wait_drained();

    // mean, width 2 taken as 3; all-max window and a truncating sum
    write_reg(wmf_pkg::CFG_FILTER_MODE, 11'h001);
    write_reg(wmf_pkg::CFG_LINE_WIDTH, 11'd2);
    for (i = 0; i < 9; i++) put(8'd255, i == 0);
    put(8'd0, 1'b0); put(8'd0, 1'b0); put(8'd8, 1'b0);
    wait_drained();

    // width lowered mid-row: column past the new width wraps to the next row
    write_reg(wmf_pkg::CFG_FILTER_MODE, 11'd0);
    write_reg(wmf_pkg::CFG_LINE_WIDTH, 11'd6);
    queue_pixels(3*6 + 5, STYLE_EXTREME, 0, 1'b1);
    wait_drained();
    write_reg(wmf_pkg::CFG_LINE_WIDTH, 11'd4);
    queue_pixels(2*4 + 2, STYLE_RANDOM, 0, 1'b0);
    wait_drained();

    // receiver holds off while the sender keeps pushing
    pace_sender = 1'b0;
    write_reg(wmf_pkg::CFG_FILTER_MODE, 11'd1);
    write_reg(wmf_pkg::CFG_LINE_WIDTH, 11'd4);
    hold_req++;
    queue_pixels(160, STYLE_RANDOM, 0, 1'b1);
    wait_drained();

    // random frames, mostly well formed, some cut short or restarted
    items_done = 0;
    while (items_done < 150) begin
      if ($urandom_range(0, 1) == 0) begin
        wait_drained();
        write_reg(wmf_pkg::CFG_FILTER_MODE, wmf_pkg::LW_W'($urandom_range(0, 2047)));
        case ($urandom_range(0, 19))
          0, 1:    write_reg(wmf_pkg::CFG_LINE_WIDTH, wmf_pkg::LW_W'($urandom_range(0, 2)));
          2, 3:    write_reg(wmf_pkg::CFG_LINE_WIDTH, wmf_pkg::LW_W'($urandom_range(13, 40)));
          default: write_reg(wmf_pkg::CFG_LINE_WIDTH, wmf_pkg::LW_W'($urandom_range(3, 12)));
        endcase
      end
      eff = eff_width_of(width_now);
      rows = ($urandom_range(0, 9) < 8) ? $urandom_range(3, 7) : $urandom_range(0, 2);
      n = rows*eff + $urandom_range(0, eff - 1);
      pace_sender = ($urandom_range(0, 3) != 0);
      queue_pixels(n, $urandom_range(0, 2), ($urandom_range(0, 9) == 0) ? 30 : 0, 1'b1);
      items_done += n;
    end
    wait_drained();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
